// ===== rtl/core/smf_pkg.sv =====
// Shared types for the sliding median filter.
`timescale 1ns / 1ps

package smf_pkg;

    // Control signals one cell hands to the next cell up the sorted row.
    typedef struct packed {
        logic shifted;  // The oldest sample sits at or below this position.
        logic le;       // The surviving entry here is not above the new sample.
    } t_link;

endpackage

// ===== rtl/core/smf_cell.sv =====
// One cell of the sorted window: holds one sample and its age.
`timescale 1ns / 1ps

module smf_cell #(
    parameter int WIN_LEN     = 7,
    parameter int SAMPLE_BITS = 16,
    parameter int INDEX       = 0,
    parameter bit IS_LAST     = 1'b0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    // Neighbor below (lower rank).
    input  smf_pkg::t_link                i_prev_link,
    input  logic signed [SAMPLE_BITS-1:0] i_prev_rem_val,
    input  logic [$clog2(WIN_LEN)-1:0]    i_prev_rem_age,
    // Neighbor above (higher rank).
    input  logic signed [SAMPLE_BITS-1:0] i_next_val,
    input  logic [$clog2(WIN_LEN)-1:0]    i_next_age,
    // Own state and what this cell hands upward.
    output logic signed [SAMPLE_BITS-1:0] o_val,
    output logic [$clog2(WIN_LEN)-1:0]    o_age,
    output smf_pkg::t_link                o_link,
    output logic signed [SAMPLE_BITS-1:0] o_rem_val,
    output logic [$clog2(WIN_LEN)-1:0]    o_rem_age
);

    localparam int AW = $clog2(WIN_LEN);
    localparam logic [AW-1:0] RST_AGE = AW'(INDEX);
    localparam logic [AW-1:0] OLDEST  = AW'(WIN_LEN - 1);

    logic signed [SAMPLE_BITS-1:0] r_val, n_val;
    logic [AW-1:0]                 r_age, n_age;
    logic                          w_shifted;
    logic                          w_le;

    // Entry at this rank once the oldest sample is taken out of the row.
    assign w_shifted = i_prev_link.shifted | (r_age == OLDEST);
    assign o_rem_val = w_shifted ? i_next_val : r_val;
    assign o_rem_age = w_shifted ? i_next_age : r_age;

    // The top cell has no surviving entry of its own after the removal.
    assign w_le = IS_LAST ? 1'b0 : (o_rem_val <= i_sample);

    assign o_link.shifted = w_shifted;
    assign o_link.le      = w_le;

    // Insert the new sample: keep own survivor, take the sample, or move the one below up.
    always_comb begin
        if (w_le) begin
            n_val = o_rem_val;
            n_age = AW'(o_rem_age + 1'b1);
        end else if (i_prev_link.le) begin
            n_val = i_sample;
            n_age = '0;
        end else begin
            n_val = i_prev_rem_val;
            n_age = AW'(i_prev_rem_age + 1'b1);
        end
    end

    // Window starts as zeros with distinct ages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
            r_age <= RST_AGE;
        end else if (i_en) begin
            r_val <= n_val;
            r_age <= n_age;
        end
    end

    assign o_val = r_val;
    assign o_age = r_age;

endmodule

// ===== rtl/core/sliding_median_filter.sv =====
// Top level of the sliding-window median filter.
`timescale 1ns / 1ps
//
// Usage: the input channel (i_valid, o_ready, i_sample) takes one signed
// sample per request. Each sample replaces the oldest of the last WIN_LEN
// samples, and the output channel (o_valid, i_ready, o_median) returns one
// request holding the median of that window, the value at sorted position
// (WIN_LEN-1)/2 counted from the smallest.
// The window is a row of cells kept in sorted order, each with the age of
// its sample; on a request every cell drops the oldest entry and inserts
// the new sample, so the median appears in the cycle after the sample is
// taken. Throughput is one sample per cycle while the receiver keeps
// i_ready high; the cell row's compare-and-shift path sets that.
// When the receiver stalls, the median is held and o_ready drops until it
// is taken; o_ready rises in the same cycle that the result is consumed.
// Reset (synchronous, active low) fills the window with zeros, which are
// ranked like real samples until enough samples have replaced them, and
// clears any pending result.

module sliding_median_filter #(
    parameter int WIN_LEN     = 7,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_median
);

    localparam int AW  = $clog2(WIN_LEN);
    localparam int MID = (WIN_LEN - 1) / 2;

    logic                          w_accept;
    logic                          r_valid;
    logic signed [SAMPLE_BITS-1:0] w_val     [WIN_LEN];
    logic [AW-1:0]                 w_age     [WIN_LEN];
    logic signed [SAMPLE_BITS-1:0] w_rem_val [WIN_LEN];
    logic [AW-1:0]                 w_rem_age [WIN_LEN];
    smf_pkg::t_link                w_link    [WIN_LEN];

    assign o_ready  = ~r_valid | i_ready;
    assign w_accept = i_valid & o_ready;

    // Row of sorted cells, lowest rank first.
    for (genvar g = 0; g < WIN_LEN; g++) begin : g_cell
        smf_pkg::t_link                w_prev_link;
        logic signed [SAMPLE_BITS-1:0] w_prev_val;
        logic [AW-1:0]                 w_prev_age;
        logic signed [SAMPLE_BITS-1:0] w_next_val;
        logic [AW-1:0]                 w_next_age;

        if (g == 0) begin : g_first
            assign w_prev_link.shifted = 1'b0;
            assign w_prev_link.le      = 1'b1;
            assign w_prev_val          = '0;
            assign w_prev_age          = '0;
        end else begin : g_inner
            assign w_prev_link = w_link[g-1];
            assign w_prev_val  = w_rem_val[g-1];
            assign w_prev_age  = w_rem_age[g-1];
        end

        if (g == WIN_LEN - 1) begin : g_top
            assign w_next_val = '0;
            assign w_next_age = '0;
        end else begin : g_below
            assign w_next_val = w_val[g+1];
            assign w_next_age = w_age[g+1];
        end

        smf_cell #(
            .WIN_LEN     (WIN_LEN),
            .SAMPLE_BITS (SAMPLE_BITS),
            .INDEX       (g),
            .IS_LAST     (g == WIN_LEN - 1)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_en           (w_accept),
            .i_sample       (i_sample),
            .i_prev_link    (w_prev_link),
            .i_prev_rem_val (w_prev_val),
            .i_prev_rem_age (w_prev_age),
            .i_next_val     (w_next_val),
            .i_next_age     (w_next_age),
            .o_val          (w_val[g]),
            .o_age          (w_age[g]),
            .o_link         (w_link[g]),
            .o_rem_val      (w_rem_val[g]),
            .o_rem_age      (w_rem_age[g])
        );
    end

    // Result pending flag; the middle cell itself holds the median.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid  = r_valid;
    assign o_median = w_val[MID];

endmodule
